@@ rtl/core/bchg_pkg.sv @@
`default_nettype none

package bchg_pkg;

    localparam int STAMP_W  = 32;
    localparam int TIME_W   = 16;
    localparam int VOL_W    = 7;
    localparam int CLICK_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [VOL_W-1:0]   VOLUME_MAX   = 7'd100;
    localparam logic [VOL_W-1:0]   VOLUME_RESET = 7'd50;
    localparam logic [CLICK_W-1:0] CLICKS_MAX   = 2'd3;

    localparam logic [TIME_W-1:0] HOLD_MS_RESET       = 16'd400;
    localparam logic [TIME_W-1:0] SERIES_GAP_MS_RESET = 16'd400;
    localparam logic [TIME_W-1:0] REPEAT_MS_RESET     = 16'd150;
    localparam logic [TIME_W-1:0] DEBOUNCE_MS_RESET   = 16'd20;
    localparam logic [TIME_W-1:0] SETTLE_MS_RESET     = 16'd350;
    localparam logic [VOL_W-1:0]  VOLUME_STEP_RESET   = 7'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_MS       = 3'd0,
        CFG_SERIES_GAP_MS = 3'd1,
        CFG_REPEAT_MS     = 3'd2,
        CFG_DEBOUNCE_MS   = 3'd3,
        CFG_SETTLE_MS     = 3'd4,
        CFG_VOLUME_STEP   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_PAUSE = 2'd1,
        ACT_NEXT  = 2'd2,
        ACT_PREV  = 2'd3
    } action_t;

    typedef struct packed {
        logic               pressed;
        logic [STAMP_W-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [VOL_W-1:0] volume_level;
        logic             volume_changed;
    } out_t;

endpackage

`default_nettype wire

@@ rtl/core/button_click_hold_gesture_unit.sv @@
// Button click and hold gesture unit.
// The in channel carries one button level sample with its millisecond
// timestamp per transfer; the out channel returns one result per sample:
// the action code, the volume after that sample and a volume step flag.
// The cfg channel writes the timing registers and the volume step; it is
// always ready and should only be used while no sample is in flight.
// A sample is held in an input register; the gesture logic then updates
// the state and loads the result register, so a result follows its
// transfer in through those two registers. One sample per cycle is
// sustained while out_ready stays high: the state update is one pass of
// 32-bit subtracts and compares between the input and result registers.
// When the receiver stalls, the result register holds and the input
// register takes one more sample; in_ready falls once both are full.
// Reset empties both registers, loads the default timings and sets the
// volume to 50 with no press, no clicks and all stamps at zero.
`default_nettype none

module button_click_hold_gesture_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire bchg_pkg::in_t                     in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output bchg_pkg::out_t                         out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bchg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bchg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bchg_pkg::*;

    logic [TIME_W-1:0] hold_ms_reg;
    logic [TIME_W-1:0] series_gap_ms_reg;
    logic [TIME_W-1:0] repeat_ms_reg;
    logic [TIME_W-1:0] debounce_ms_reg;
    logic [TIME_W-1:0] settle_ms_reg;
    logic [VOL_W-1:0]  volume_step_reg;

    logic               was_pressed_reg, was_pressed_next;
    logic [STAMP_W-1:0] press_stamp_reg, press_stamp_next;
    logic [STAMP_W-1:0] release_stamp_reg, release_stamp_next;
    logic [STAMP_W-1:0] repeat_stamp_reg, repeat_stamp_next;
    logic [CLICK_W-1:0] clicks_reg, clicks_next;
    logic               hold_done_reg, hold_done_next;
    logic [VOL_W-1:0]   volume_reg, volume_next;

    logic in_full_reg;
    in_t  in_hold_reg;
    logic out_full_reg;
    out_t out_reg, out_next;

    logic advance;

    logic               pressed;
    logic [STAMP_W-1:0] now;
    logic               press_edge, release_edge, fire, settle_hit;
    logic [STAMP_W-1:0] since_release, since_press, since_repeat;
    logic [STAMP_W-1:0] press_stamp_1;
    logic [CLICK_W-1:0] clicks_1, clicks_2;
    logic               hold_done_1;
    logic [VOL_W:0]     vol_up;
    logic [1:0]         action;
    logic               changed;

    assign advance   = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;
    assign out_valid = out_full_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    assign pressed = in_hold_reg.pressed;
    assign now     = in_hold_reg.now_ms;

    always_comb
    begin
        press_edge   = pressed && !was_pressed_reg;
        release_edge = !pressed && was_pressed_reg;

        // press edge
        since_release = now - release_stamp_reg;
        press_stamp_1 = press_edge ? now : press_stamp_reg;
        hold_done_1   = press_edge ? 1'b0 : hold_done_reg;
        clicks_1      = clicks_reg;
        if (press_edge && (since_release > {16'd0, series_gap_ms_reg}))
        begin
            clicks_1 = '0;
        end

        // hold repeat
        since_press  = now - press_stamp_1;
        since_repeat = now - repeat_stamp_reg;
        fire = pressed && (since_press > {16'd0, hold_ms_reg})
               && (since_repeat > {16'd0, repeat_ms_reg});

        repeat_stamp_next = repeat_stamp_reg;
        hold_done_next    = hold_done_1;
        volume_next       = volume_reg;
        changed           = 1'b0;
        vol_up            = {1'b0, volume_reg} + {1'b0, volume_step_reg};
        if (fire)
        begin
            repeat_stamp_next = now;
            hold_done_next    = 1'b1;
            if (clicks_1 == 2'd0)
            begin
                volume_next = (vol_up > {1'b0, VOLUME_MAX}) ? VOLUME_MAX
                                                           : vol_up[VOL_W-1:0];
                changed = 1'b1;
            end
            else if (clicks_1 == 2'd1)
            begin
                volume_next = (volume_reg > volume_step_reg)
                              ? (volume_reg - volume_step_reg) : '0;
                changed = 1'b1;
            end
        end

        // release edge; no repeat can fire here, so the press state is as stored
        release_stamp_next = release_edge ? now : release_stamp_reg;
        clicks_2 = clicks_1;
        if (release_edge)
        begin
            if (hold_done_1)
            begin
                clicks_2 = '0;
            end
            else if ((since_press > {16'd0, debounce_ms_reg}) && (clicks_1 != CLICKS_MAX))
            begin
                clicks_2 = clicks_1 + 2'd1;
            end
        end

        // settle: the click count maps straight onto the action code
        settle_hit = !pressed && (clicks_2 != 2'd0)
                     && ((now - release_stamp_next) > {16'd0, settle_ms_reg});
        action      = settle_hit ? clicks_2 : ACT_NONE;
        clicks_next = settle_hit ? '0 : clicks_2;

        press_stamp_next = press_stamp_1;
        was_pressed_next = pressed;

        out_next.action         = action;
        out_next.volume_level   = volume_next;
        out_next.volume_changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg       <= 1'b0;
            out_full_reg      <= 1'b0;
            was_pressed_reg   <= 1'b0;
            press_stamp_reg   <= '0;
            release_stamp_reg <= '0;
            repeat_stamp_reg  <= '0;
            clicks_reg        <= '0;
            hold_done_reg     <= 1'b0;
            volume_reg        <= VOLUME_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_full_reg <= in_valid;
            end
            if (advance)
            begin
                out_full_reg      <= 1'b1;
                was_pressed_reg   <= was_pressed_next;
                press_stamp_reg   <= press_stamp_next;
                release_stamp_reg <= release_stamp_next;
                repeat_stamp_reg  <= repeat_stamp_next;
                clicks_reg        <= clicks_next;
                hold_done_reg     <= hold_done_next;
                volume_reg        <= volume_next;
            end
            else if (out_ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg       <= HOLD_MS_RESET;
            series_gap_ms_reg <= SERIES_GAP_MS_RESET;
            repeat_ms_reg     <= REPEAT_MS_RESET;
            debounce_ms_reg   <= DEBOUNCE_MS_RESET;
            settle_ms_reg     <= SETTLE_MS_RESET;
            volume_step_reg   <= VOLUME_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HOLD_MS:       hold_ms_reg       <= cfg_data;
                CFG_SERIES_GAP_MS: series_gap_ms_reg <= cfg_data;
                CFG_REPEAT_MS:     repeat_ms_reg     <= cfg_data;
                CFG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data;
                CFG_SETTLE_MS:     settle_ms_reg     <= cfg_data;
                CFG_VOLUME_STEP:   volume_step_reg   <= cfg_data[VOL_W-1:0];
                default:           ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_hold_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire
